[design/crcfhr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcfhr_pkg
// Shared types, protocol constants and the CRC-16/CCITT-FALSE byte update
// for the framed HELLO receiver.
// ----------------------------------------------------------------------------
package crcfhr_pkg;

  localparam logic [7:0]  SYNC_A       = 8'hD3;
  localparam logic [7:0]  SYNC_B       = 8'h91;
  localparam logic [7:0]  VER_CODE     = 8'h01;
  localparam logic [7:0]  ID_BLUE      = 8'h02;
  localparam logic [7:0]  ID_RED       = 8'h03;
  localparam logic [7:0]  TYPE_HELLO   = 8'h50;
  localparam logic [7:0]  TYPE_ACK     = 8'h7F;
  localparam logic [7:0]  PAYLOAD_FLAG = 8'h80;
  localparam logic [4:0]  FULL_MASK    = 5'h1F;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;

  // largest accepted payload length
  localparam int unsigned MAX_PAYLOAD_BYTES = 128;
  // header, length, check and trailer bytes around the payload
  localparam logic [7:0]  EXTRA_BYTES  = 8'd15;
  localparam logic [15:0] HELLO_LEN    = 16'd8;

  // ACK frame byte positions
  localparam int unsigned ACK_LEN      = 19;
  localparam logic [4:0]  ACK_CRC_FIRST = 5'd2;
  localparam logic [4:0]  ACK_CRC_LAST  = 5'd14;
  localparam logic [4:0]  ACK_LAST_IDX  = 5'(ACK_LEN - 1);

  localparam logic [7:0]  STATUS_OK    = 8'h00;
  localparam logic [7:0]  STATUS_FAIL  = 8'h04;

  typedef struct packed {
    logic [15:0] seq;
    logic [4:0]  mask;
  } ack_job_t;

  typedef struct packed {
    logic     valid;
    ack_job_t job;
  } job_xfer_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/crcfhr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcfhr_front
// Frame parser: hunts the header, collects fields, runs the CRC and builds
// the check mask at the last byte; HELLOs with good ids/trailer queue ACKs.
// ----------------------------------------------------------------------------
module crcfhr_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    byte_en,
  input  wire  [7:0]             rx_byte,
  output crcfhr_pkg::job_xfer_t  push
);

  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  total_r, total_nxt;
  logic        trailer_r, trailer_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rcv_r, rcv_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [7:0]  ver_r, src_r, dst_r, typ_r;
  logic [7:0]  ph0_r, ph1_r, ph2_r, ph3_r;

  logic [8:0]  pos9, tot9;
  logic [15:0] len;
  logic [15:0] frame_len;
  logic [4:0]  mask;
  logic        finish;

  assign pos9      = {1'b0, pos_r};
  assign tot9      = {1'b0, total_r};
  assign len       = {rx_byte, rcv_r[7:0]};
  assign frame_len = {8'h00, total_r - crcfhr_pkg::EXTRA_BYTES};

  always_comb begin
    mask[0] = trailer_r && (rx_byte == crcfhr_pkg::SYNC_A);
    mask[1] = (ver_r == crcfhr_pkg::VER_CODE);
    mask[2] = (src_r == crcfhr_pkg::ID_RED) && (dst_r == crcfhr_pkg::ID_BLUE);
    mask[3] = (typ_r == crcfhr_pkg::TYPE_HELLO) && (frame_len == crcfhr_pkg::HELLO_LEN)
              && (ph0_r == crcfhr_pkg::ID_BLUE) && (ph1_r == crcfhr_pkg::VER_CODE)
              && (ph2_r == crcfhr_pkg::PAYLOAD_FLAG) && (ph3_r == 8'h00);
    mask[4] = (rcv_r == crc_r);
  end

  always_comb begin
    pos_nxt     = pos_r;
    total_nxt   = total_r;
    trailer_nxt = trailer_r;
    crc_nxt     = crc_r;
    rcv_nxt     = rcv_r;
    seq_nxt     = seq_r;
    finish      = 1'b0;
    if (byte_en) begin
      if (pos_r == 8'd0) begin
        if (rx_byte == crcfhr_pkg::SYNC_A) pos_nxt = 8'd1;
      end else if (pos_r == 8'd1) begin
        if (rx_byte == crcfhr_pkg::SYNC_B) begin
          pos_nxt     = 8'd2;
          crc_nxt     = crcfhr_pkg::CRC_INIT;
          trailer_nxt = 1'b0;
        end else begin
          pos_nxt = (rx_byte == crcfhr_pkg::SYNC_A) ? 8'd1 : 8'd0;
        end
      end else begin
        pos_nxt = pos_r + 8'd1;
        if (pos_r == 8'd7) seq_nxt = {seq_r[15:8], rx_byte};
        if (pos_r == 8'd8) seq_nxt = {rx_byte, seq_r[7:0]};
        if (pos_r == 8'd9) rcv_nxt = {8'h00, rx_byte};
        if ((pos_r <= 8'd10) || (pos9 + 9'd5 <= tot9))
          crc_nxt = crcfhr_pkg::crc16_byte(crc_r, rx_byte);
        if (pos_r == 8'd10) begin
          if (len > 16'(crcfhr_pkg::MAX_PAYLOAD_BYTES)) begin
            pos_nxt     = 8'd0;
            total_nxt   = 8'd0;
            trailer_nxt = 1'b0;
          end else begin
            total_nxt = len[7:0] + crcfhr_pkg::EXTRA_BYTES;
          end
        end else if (total_r != 8'd0) begin
          if (pos9 + 9'd4 == tot9) begin
            rcv_nxt = {rcv_r[15:8], rx_byte};
          end else if (pos9 + 9'd3 == tot9) begin
            rcv_nxt = {rx_byte, rcv_r[7:0]};
          end else if (pos9 + 9'd2 == tot9) begin
            trailer_nxt = (rx_byte == crcfhr_pkg::SYNC_B);
          end else if (pos9 + 9'd1 == tot9) begin
            finish      = 1'b1;
            pos_nxt     = 8'd0;
            total_nxt   = 8'd0;
            trailer_nxt = 1'b0;
          end
        end
      end
    end
  end

  assign push.valid    = finish && mask[0] && mask[2] && (typ_r == crcfhr_pkg::TYPE_HELLO);
  assign push.job.seq  = seq_r;
  assign push.job.mask = mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 8'd0;
      total_r   <= 8'd0;
      trailer_r <= 1'b0;
      crc_r     <= crcfhr_pkg::CRC_INIT;
      rcv_r     <= 16'h0000;
      seq_r     <= 16'h0000;
    end else begin
      pos_r     <= pos_nxt;
      total_r   <= total_nxt;
      trailer_r <= trailer_nxt;
      crc_r     <= crc_nxt;
      rcv_r     <= rcv_nxt;
      seq_r     <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && (pos_r == 8'd2)) ver_r <= rx_byte;
    if (byte_en && (pos_r == 8'd3)) src_r <= rx_byte;
    if (byte_en && (pos_r == 8'd4)) dst_r <= rx_byte;
    if (byte_en && (pos_r == 8'd5)) typ_r <= rx_byte;
    if (byte_en && (pos_r == 8'd11)) ph0_r <= rx_byte;
    if (byte_en && (pos_r == 8'd12)) ph1_r <= rx_byte;
    if (byte_en && (pos_r == 8'd13)) ph2_r <= rx_byte;
    if (byte_en && (pos_r == 8'd14)) ph3_r <= rx_byte;
  end

endmodule
`default_nettype wire

[design/crcfhr_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcfhr_queue
// Two-entry job queue between the frame parser and the ACK generator.
// ----------------------------------------------------------------------------
module crcfhr_queue (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire crcfhr_pkg::job_xfer_t push,
  input  wire                        pop,
  output crcfhr_pkg::job_xfer_t      head,
  output logic                       full
);

  crcfhr_pkg::ack_job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.valid ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push.valid} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.job;
  end

endmodule
`default_nettype wire

[design/crcfhr_ack_gen.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcfhr_ack_gen
// Streams the 19-byte ACK frame for each queued job through an output
// register, computing the frame CRC on the fly.
// ----------------------------------------------------------------------------
module crcfhr_ack_gen (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire crcfhr_pkg::job_xfer_t head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [7:0]                 out_tx_byte,
  output logic                       out_last_of_ack,
  output logic                       out_link_verified
);

  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        valid_r;
  logic [7:0]  byte_r;
  logic        last_r, verified_r;

  logic        advance;
  logic        verified;
  logic [7:0]  status;
  logic [7:0]  cur_byte;

  assign advance  = head.valid && (!valid_r || !out_stall);
  assign verified = (head.job.mask == crcfhr_pkg::FULL_MASK);
  assign status   = verified ? crcfhr_pkg::STATUS_OK : crcfhr_pkg::STATUS_FAIL;
  assign pop      = advance && (idx_r == crcfhr_pkg::ACK_LAST_IDX);

  always_comb begin
    unique case (idx_r)
      5'd0:    cur_byte = crcfhr_pkg::SYNC_A;
      5'd1:    cur_byte = crcfhr_pkg::SYNC_B;
      5'd2:    cur_byte = crcfhr_pkg::VER_CODE;
      5'd3:    cur_byte = crcfhr_pkg::ID_BLUE;
      5'd4:    cur_byte = crcfhr_pkg::ID_RED;
      5'd5:    cur_byte = crcfhr_pkg::TYPE_ACK;
      5'd6:    cur_byte = crcfhr_pkg::ID_BLUE;
      5'd7:    cur_byte = head.job.seq[7:0];
      5'd8:    cur_byte = head.job.seq[15:8];
      5'd9:    cur_byte = 8'h04;
      5'd10:   cur_byte = 8'h00;
      5'd11:   cur_byte = crcfhr_pkg::TYPE_HELLO;
      5'd12:   cur_byte = status;
      5'd13:   cur_byte = {3'b000, head.job.mask};
      5'd14:   cur_byte = 8'h00;
      5'd15:   cur_byte = crc_r[7:0];
      5'd16:   cur_byte = crc_r[15:8];
      5'd17:   cur_byte = crcfhr_pkg::SYNC_B;
      5'd18:   cur_byte = crcfhr_pkg::SYNC_A;
      default: cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    if (advance) begin
      idx_nxt = (idx_r == crcfhr_pkg::ACK_LAST_IDX) ? 5'd0 : idx_r + 5'd1;
      if (idx_r == 5'd0)
        crc_nxt = crcfhr_pkg::CRC_INIT;
      else if ((idx_r >= crcfhr_pkg::ACK_CRC_FIRST) && (idx_r <= crcfhr_pkg::ACK_CRC_LAST))
        crc_nxt = crcfhr_pkg::crc16_byte(crc_r, cur_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 5'd0;
      crc_r   <= crcfhr_pkg::CRC_INIT;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      if (advance) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r     <= cur_byte;
      last_r     <= (idx_r == crcfhr_pkg::ACK_LAST_IDX);
      verified_r <= verified;
    end
  end

  assign out_valid         = valid_r;
  assign out_tx_byte       = byte_r;
  assign out_last_of_ack   = last_r;
  assign out_link_verified = verified_r;

endmodule
`default_nettype wire

[design/crc_framed_hello_receiver_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crc_framed_hello_receiver_unit
// Framed HELLO receiver: parses D3 91 framed packets, checks them and
// answers each HELLO with good ids and trailer with a 19-byte ACK frame.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while in_stall is low; the
// parser updates the frame CRC one byte per cycle. A frame that earns an
// ACK queues a job in a two-entry queue, and the ACK generator sends one
// ACK byte per cycle when the output is not stalled. in_stall rises only
// while both queue entries hold pending ACKs. When the ACK generator is
// idle, the job is queued, then the first ACK byte enters the output register.
// ----------------------------------------------------------------------------
module crc_framed_hello_receiver_unit (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_rx_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_last_of_ack,
  output logic       out_link_verified
);

  crcfhr_pkg::job_xfer_t push;
  crcfhr_pkg::job_xfer_t head;
  logic                  pop;
  logic                  full;
  logic                  byte_en;

  assign in_stall = full;
  assign byte_en  = in_valid && !full;

  crcfhr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (in_rx_byte),
    .push    (push)
  );

  crcfhr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (full)
  );

  crcfhr_ack_gen u_ack_gen (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_byte       (out_tx_byte),
    .out_last_of_ack   (out_last_of_ack),
    .out_link_verified (out_link_verified)
  );

endmodule
`default_nettype wire
